/* rtl/core/fhp_pkg.sv */
`timescale 1ns / 1ps

package fhp_pkg;

  localparam int unsigned HDR_LEN = 56;
  localparam int unsigned POS_W = 6;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(HDR_LEN - 1);
  localparam int unsigned MAGIC_LEN = 8;

  localparam logic [7:0] MAGIC [MAGIC_LEN] = '{
    8'h44, 8'h45, 8'h44, 8'h46, 8'h52, 8'h4D, 8'h31, 8'h00
  };

  localparam logic [31:0] VER_PLAIN = 32'd1;
  localparam logic [31:0] VER_EGO = 32'd2;
  localparam logic [31:0] FMT_RGB8 = 32'd1;
  localparam logic [31:0] RGB_CHANNELS = 32'd3;

  // field group selected by byte position bits [5:2]
  typedef enum logic [3:0] {
    GRP_MAGIC0   = 4'd0,
    GRP_MAGIC1   = 4'd1,
    GRP_HDR_SIZE = 4'd2,
    GRP_VERSION  = 4'd3,
    GRP_SEQ_LO   = 4'd4,
    GRP_SEQ_HI   = 4'd5,
    GRP_TS_LO    = 4'd6,
    GRP_TS_HI    = 4'd7,
    GRP_WIDTH    = 4'd8,
    GRP_HEIGHT   = 4'd9,
    GRP_CHANNELS = 4'd10,
    GRP_FORMAT   = 4'd11,
    GRP_PAYLOAD  = 4'd12,
    GRP_SIDECAR  = 4'd13
  } field_grp_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_MAGIC   = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_BAD_SHAPE   = 3'd3,
    ST_BAD_PAYLOAD = 3'd4,
    ST_V1_SIDECAR  = 3'd5
  } status_t;

  typedef struct packed {
    logic [31:0] hdr_size;
    logic [31:0] version;
    logic [63:0] sequence_num;
    logic [63:0] timestamp;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] channels;
    logic [31:0] format;
    logic [31:0] payload;
    logic [31:0] sidecar;
  } hdr_fields_t;

  typedef struct packed {
    logic        magic_ok;
    logic        last;
    logic [31:0] area3;
  } collect_stat_t;

endpackage

/* rtl/core/fhp_collect.sv */
`timescale 1ns / 1ps

module fhp_collect (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [7:0]                data_byte,
  output fhp_pkg::hdr_fields_t      fields,
  output fhp_pkg::collect_stat_t    stat
);

  logic [fhp_pkg::POS_W-1:0] pos;
  logic                      magic_ok;
  logic                      last;
  logic [31:0]               area;
  logic [31:0]               area3;
  fhp_pkg::hdr_fields_t      hdr;
  fhp_pkg::field_grp_t       grp;

  assign last = (pos == fhp_pkg::LAST_POS);
  assign grp = fhp_pkg::field_grp_t'(pos[5:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      magic_ok <= 1'b1;
    end else if (accept) begin
      if (last) begin
        pos <= '0;
        magic_ok <= 1'b1;
      end else begin
        pos <= pos + 1'b1;
        if (pos[5:3] == 3'd0 && data_byte != fhp_pkg::MAGIC[pos[2:0]]) begin
          magic_ok <= 1'b0;
        end
      end
    end
  end

  // little-endian byte lanes; every lane is rewritten in each header
  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (grp)
        fhp_pkg::GRP_MAGIC0, fhp_pkg::GRP_MAGIC1: ;
        fhp_pkg::GRP_HDR_SIZE: hdr.hdr_size[8*pos[1:0] +: 8] <= data_byte;
        fhp_pkg::GRP_VERSION:  hdr.version[8*pos[1:0] +: 8] <= data_byte;
        fhp_pkg::GRP_SEQ_LO,
        fhp_pkg::GRP_SEQ_HI:   hdr.sequence_num[8*pos[2:0] +: 8] <= data_byte;
        fhp_pkg::GRP_TS_LO,
        fhp_pkg::GRP_TS_HI:    hdr.timestamp[8*pos[2:0] +: 8] <= data_byte;
        fhp_pkg::GRP_WIDTH:    hdr.width[8*pos[1:0] +: 8] <= data_byte;
        fhp_pkg::GRP_HEIGHT:   hdr.height[8*pos[1:0] +: 8] <= data_byte;
        fhp_pkg::GRP_CHANNELS: hdr.channels[8*pos[1:0] +: 8] <= data_byte;
        fhp_pkg::GRP_FORMAT:   hdr.format[8*pos[1:0] +: 8] <= data_byte;
        fhp_pkg::GRP_PAYLOAD:  hdr.payload[8*pos[1:0] +: 8] <= data_byte;
        fhp_pkg::GRP_SIDECAR:  hdr.sidecar[8*pos[1:0] +: 8] <= data_byte;
        default: ;
      endcase
    end
  end

  // Width and height settle by byte 39; the two product stages have long
  // caught up by byte 55. The payload check only matters when channels is 3.
  always_ff @(posedge clk) begin
    area <= 32'(hdr.width * hdr.height);
    area3 <= area + {area[30:0], 1'b0};
  end

  assign fields = hdr;
  assign stat = '{magic_ok: magic_ok, last: last, area3: area3};

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= fhp_pkg::LAST_POS)
    else $error("byte position beyond header length");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> pos == '0 && magic_ok)
    else $error("position did not wrap after final byte");

  a_magic_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(pos) && $stable(magic_ok))
    else $error("parser state moved without a transaction");

endmodule

/* rtl/core/frame_header_parser.sv */
`timescale 1ns / 1ps
// Throughput: one header byte per cycle while the input is not stalled.
// The result is registered and shows in the cycle after the 56th byte is accepted.
// The input stalls only on a final byte while the previous result is still held.
// Reset clears byte position, magic flag and result valid; field registers
// are rewritten by every header and need no reset.

module frame_header_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [31:0]        version_seen,
  output logic [63:0]        sequence_number,
  output logic signed [63:0] timestamp_nanos,
  output logic [31:0]        image_width,
  output logic [31:0]        image_height,
  output logic [31:0]        payload_bytes,
  output logic [31:0]        sidecar_bytes
);

  fhp_pkg::hdr_fields_t   fields;
  fhp_pkg::collect_stat_t stat;
  fhp_pkg::status_t       status_next;
  logic                   in_acc;
  logic                   out_acc;
  logic [31:0]            sidecar_final;

  assign in_stall = stat.last && out_valid && out_stall;
  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  fhp_collect u_collect (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_acc),
    .data_byte (data_byte),
    .fields    (fields),
    .stat      (stat)
  );

  // the final byte is the top lane of the sidecar size
  assign sidecar_final = {data_byte, fields.sidecar[23:0]};

  always_comb begin
    priority if (!stat.magic_ok) begin
      status_next = fhp_pkg::ST_BAD_MAGIC;
    end else if (fields.hdr_size != 32'(fhp_pkg::HDR_LEN) ||
                 (fields.version != fhp_pkg::VER_PLAIN &&
                  fields.version != fhp_pkg::VER_EGO)) begin
      status_next = fhp_pkg::ST_BAD_VERSION;
    end else if (fields.width == '0 || fields.height == '0 ||
                 fields.channels != fhp_pkg::RGB_CHANNELS ||
                 fields.format != fhp_pkg::FMT_RGB8) begin
      status_next = fhp_pkg::ST_BAD_SHAPE;
    end else if (fields.payload != stat.area3) begin
      status_next = fhp_pkg::ST_BAD_PAYLOAD;
    end else if (fields.version == fhp_pkg::VER_PLAIN && sidecar_final != '0) begin
      status_next = fhp_pkg::ST_V1_SIDECAR;
    end else begin
      status_next = fhp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && stat.last) begin
      out_valid <= 1'b1;
    end else if (out_acc) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && stat.last) begin
      status <= status_next;
      version_seen <= fields.version;
      sequence_number <= fields.sequence_num;
      timestamp_nanos <= signed'(fields.timestamp);
      image_width <= fields.width;
      image_height <= fields.height;
      payload_bytes <= fields.payload;
      sidecar_bytes <= sidecar_final;
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_acc && stat.last |=> out_valid)
    else $error("final byte did not produce a result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_acc && stat.last))
    else $error("result raised without a final byte");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && stat.last)
    else $error("input stalled while result slot free");

endmodule
